// ===== rtl/core/s2l_pkg.sv =====
// ----------------------------------------------------------------------------
// s2l_pkg
// Types, constants and the sRGB gamma-decode table for srgb_to_cielab.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int FracBits = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic        [14:0] l_star;
    logic signed [15:0] a_star;
    logic signed [15:0] b_star;
  } res_t;

  typedef enum logic [1:0] {
    CfgInvWhiteX = 2'd0,
    CfgInvWhiteY = 2'd1,
    CfgInvWhiteZ = 2'd2
  } cfg_idx_e;

  localparam logic [16:0] InvWhiteXRst = 17'd68951;
  localparam logic [16:0] InvWhiteYRst = 17'd65536;
  localparam logic [16:0] InvWhiteZRst = 17'd60189;

  typedef logic [16:0] lin_tab_t [256];
  typedef logic [15:0] coef_t [3][3];

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p2;
    longint unsigned p4;
    p2 = (r * r) >> 30;
    p4 = (p2 * p2) >> 30;
    return (p4 * r) >> 30;
  endfunction

  // evaluated at elaboration only
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t        tab;
    longint unsigned n;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        v = ((longint'(i) * 100) << FracBits);
        v = (v + 164730) / 329460;
      end else begin
        n  = 1000 * longint'(i) + 14025;
        t  = (n << 30) / 269025;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (pow5_q30(mid) <= t2) lo = mid;
          else hi = mid - 1;
        end
        v = (t2 * lo) >> 30;
        v = (v + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
      end
      tab[i] = 17'(v);
    end
    return tab;
  endfunction

  function automatic logic [15:0] coef_q(longint unsigned c7);
    return 16'(((c7 << FracBits) + 5000000) / 10000000);
  endfunction

  localparam lin_tab_t LinTab = build_lin_tab();

  localparam coef_t Coef = '{
    '{coef_q(4124564), coef_q(3575761), coef_q(1804375)},
    '{coef_q(2126729), coef_q(7151522), coef_q(721750)},
    '{coef_q(193339),  coef_q(1191920), coef_q(9503041)}
  };

  // depth of the lab function pipeline: two stages per result bit
  localparam int LabBits  = 18;
  localparam int LabDepth = 2 * LabBits;

endpackage

// ===== rtl/core/srgb_to_cielab.sv =====
// ----------------------------------------------------------------------------
// srgb_to_cielab
// 8-bit sRGB pixel to CIE L*a*b* in Q8.8, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle; busy stays low, the pipeline never stalls
// the depth is set by the cube root, two stages for each of its 18 bits
// reset clears all valid bits and loads the D65 reciprocal white registers
// results are strobed for one cycle; the receiver cannot stall
module srgb_to_cielab (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  s2l_pkg::pix_t       pix_i,
  output logic                res_valid_o,
  output s2l_pkg::res_t       res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i
);

  localparam int Latency = 7 + s2l_pkg::LabDepth;

  logic        accept;
  logic [16:0] inv_x_q, inv_y_q, inv_z_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= s2l_pkg::InvWhiteXRst;
      inv_y_q <= s2l_pkg::InvWhiteYRst;
      inv_z_q <= s2l_pkg::InvWhiteZRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (s2l_pkg::cfg_idx_e'(cfg_index_i))
        s2l_pkg::CfgInvWhiteX: inv_x_q <= cfg_data_i;
        s2l_pkg::CfgInvWhiteY: inv_y_q <= cfg_data_i;
        s2l_pkg::CfgInvWhiteZ: inv_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits for the stages ahead of and behind the lab function
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic lab_v;
  logic lab_vy, lab_vz;

  logic [16:0] lin_q   [3];
  logic [32:0] prod_q  [3][3];
  logic [16:0] xyz_q   [3];
  logic [33:0] wprod_q [3];
  logic [18:0] t_q     [3];
  logic [16:0] inv_w   [3];
  logic [17:0] f_w     [3];

  logic signed [29:0] v_q [3];
  logic signed [29:0] ext [3];
  s2l_pkg::res_t res_q;

  assign inv_w[0] = inv_x_q;
  assign inv_w[1] = inv_y_q;
  assign inv_w[2] = inv_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= lab_v;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q[0] <= s2l_pkg::LinTab[pix_i.red];
    lin_q[1] <= s2l_pkg::LinTab[pix_i.green];
    lin_q[2] <= s2l_pkg::LinTab[pix_i.blue];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[i][j] <= lin_q[j] * s2l_pkg::Coef[i][j];
      end
      xyz_q[i]   <= 17'(({1'b0, prod_q[i][0]} + {1'b0, prod_q[i][1]}
                       + {1'b0, prod_q[i][2]} + 34'd32768) >> 16);
      wprod_q[i] <= xyz_q[i] * inv_w[i];
      t_q[i]     <= 19'(({1'b0, wprod_q[i]} + 35'd32768) >> 16);
    end
  end

  s2l_labf u_labf_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .t_i    (t_q[0]),
    .valid_o(lab_v),
    .f_o    (f_w[0])
  );

  s2l_labf u_labf_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .t_i    (t_q[1]),
    .valid_o(lab_vy),
    .f_o    (f_w[1])
  );

  s2l_labf u_labf_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v5_q),
    .t_i    (t_q[2]),
    .valid_o(lab_vz),
    .f_o    (f_w[2])
  );

  always_comb begin
    for (int i = 0; i < 3; i++) ext[i] = $signed({12'b0, f_w[i]});
  end

  always_ff @(posedge clk_i) begin
    v_q[0] <= ext[1] * 30'sd116 - 30'sd1048576;
    v_q[1] <= (ext[0] - ext[1]) * 30'sd500;
    v_q[2] <= (ext[1] - ext[2]) * 30'sd200;
  end

  // round half up to Q8.8, then saturate
  logic signed [29:0] rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) rnd[i] = (v_q[i] + 30'sd128) >>> 8;
  end

  always_ff @(posedge clk_i) begin
    if (rnd[0] < 0)                 res_q.l_star <= '0;
    else if (rnd[0] > 30'sd25600)   res_q.l_star <= 15'd25600;
    else                            res_q.l_star <= rnd[0][14:0];
    if (rnd[1] < -30'sd32768)       res_q.a_star <= -16'sd32768;
    else if (rnd[1] > 30'sd32767)   res_q.a_star <= 16'sd32767;
    else                            res_q.a_star <= rnd[1][15:0];
    if (rnd[2] < -30'sd32768)       res_q.b_star <= -16'sd32768;
    else if (rnd[2] > 30'sd32767)   res_q.b_star <= 16'sd32767;
    else                            res_q.b_star <= rnd[2][15:0];
  end

  assign res_valid_o = v7_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##43 res_valid_o)
    else $error("result strobe missing after start transfer");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 43))
    else $error("result strobe without a start transfer");

  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lab_v == lab_vy) && (lab_v == lab_vz))
    else $error("lab function lanes out of step");

  a_l_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.l_star <= 15'd25600))
    else $error("lightness above range");

  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> ##(Latency - 7) lab_v)
    else $error("lab function depth mismatch");
`endif

endmodule

// ===== rtl/core/s2l_labf.sv =====
// ----------------------------------------------------------------------------
// s2l_labf
// CIE Lab f(t): pipelined bitwise cube root with the linear segment alongside.
// ----------------------------------------------------------------------------
module s2l_labf (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [18:0] t_i,
  output logic        valid_o,
  output logic [17:0] f_o
);

  localparam int Bits = s2l_pkg::LabBits;
  localparam int Dly  = 2 * Bits - 3;
  localparam logic [20:0] RecipM  = 21'((64'd1 << 32) / 3132);
  localparam logic [33:0] EpsKap  = 34'(216 << s2l_pkg::FracBits);
  localparam logic [25:0] LinOffs = 26'((432 << s2l_pkg::FracBits) + 1566);

  logic        va_q [Bits];
  logic        vb_q [Bits];
  logic [18:0] ta_q [Bits];
  logic [18:0] tb_q [Bits];
  logic [17:0] ra_q [Bits];
  logic [17:0] rb_q [Bits];
  logic [19:0] sq_q [Bits];

  logic        vin [Bits];
  logic [18:0] tin [Bits];
  logic [17:0] rin [Bits];

  always_comb begin
    vin[0] = valid_i;
    tin[0] = t_i;
    rin[0] = '0;
    for (int k = 1; k < Bits; k++) begin
      vin[k] = vb_q[k-1];
      tin[k] = tb_q[k-1];
      rin[k] = rb_q[k-1];
    end
  end

  // one result bit per stage pair: square, then cube and compare
  for (genvar k = 0; k < Bits; k++) begin : g_step
    localparam logic [17:0] Bit = 18'(1) << (Bits - 1 - k);
    logic [17:0] cand_a;
    logic [35:0] sq_full;
    logic [17:0] cand_b;
    logic [37:0] cube_full;
    logic [21:0] cube;

    assign cand_a    = rin[k] | Bit;
    assign sq_full   = cand_a * cand_a;
    assign cand_b    = ra_q[k] | Bit;
    assign cube_full = sq_q[k] * cand_b;
    assign cube      = cube_full[37:16];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[k] <= 1'b0;
        vb_q[k] <= 1'b0;
      end else begin
        va_q[k] <= vin[k];
        vb_q[k] <= va_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ta_q[k] <= tin[k];
      ra_q[k] <= rin[k];
      sq_q[k] <= sq_full[35:16];
      tb_q[k] <= ta_q[k];
      rb_q[k] <= (cube <= {3'b000, ta_q[k]}) ? cand_b : ra_q[k];
    end
  end

  // linear segment: (kappa t + 16) / 116 via reciprocal and one correction
  logic [33:0] kt;
  logic        cond1_q, cond2_q, cond3_q;
  logic [25:0] n1_q, n2_q;
  logic [46:0] qprod;
  logic [14:0] q0_q;
  logic [14:0] q0p1;
  logic [27:0] nxt_mul;
  logic [14:0] lin3_q;
  logic [14:0] lin_dly_q  [Dly];
  logic        cond_dly_q [Dly];

  assign kt      = t_i * 34'd24389;
  assign qprod   = n1_q * RecipM;
  assign q0p1    = q0_q + 15'd1;
  assign nxt_mul = q0p1 * 28'd3132;

  always_ff @(posedge clk_i) begin
    cond1_q <= kt > EpsKap;
    n1_q    <= kt[25:0] + LinOffs;
    cond2_q <= cond1_q;
    n2_q    <= n1_q;
    q0_q    <= qprod[46:32];
    cond3_q <= cond2_q;
    lin3_q  <= ({2'b00, n2_q} >= nxt_mul) ? q0p1 : q0_q;
    lin_dly_q[0]  <= lin3_q;
    cond_dly_q[0] <= cond3_q;
    for (int j = 1; j < Dly; j++) begin
      lin_dly_q[j]  <= lin_dly_q[j-1];
      cond_dly_q[j] <= cond_dly_q[j-1];
    end
  end

  assign valid_o = vb_q[Bits-1];
  assign f_o     = cond_dly_q[Dly-1] ? rb_q[Bits-1] : {3'b000, lin_dly_q[Dly-1]};

endmodule

// ===== sim/srgb_lab_checker.sv =====
// ----------------------------------------------------------------------------
// srgb_lab_checker
// Watches the pixel, config and result channels of srgb_to_cielab, computes
// the expected L*a*b* for every accepted pixel and compares results in order.
// ----------------------------------------------------------------------------
module srgb_lab_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  s2l_pkg::pix_t pix_i,
  input  logic          res_valid_o,
  input  s2l_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [16:0]   cfg_data_i,
  output int            fail_cnt_o,
  output int            pending_o,
  output int            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  longint unsigned lin_lut [256];
  longint unsigned mat_q [3][3];
  logic [16:0]     white_x, white_y, white_z;
  s2l_pkg::res_t   lab_expected [$];

  function automatic longint unsigned fifth_q30(longint unsigned r);
    longint unsigned sq;
    longint unsigned qd;
    sq = (r * r) >> 30;
    qd = (sq * sq) >> 30;
    return (qd * r) >> 30;
  endfunction

  initial begin
    longint unsigned n, t, t2, lo, hi, mid, v;
    longint unsigned c7 [3][3];
    c7 = '{'{4124564, 3575761, 1804375},
           '{2126729, 7151522, 721750},
           '{193339, 1191920, 9503041}};
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        v = ((longint'(i) * 100) << 16) + 164730;
        lin_lut[i] = v / 329460;
      end else begin
        n  = 1000 * longint'(i) + 14025;
        t  = (n << 30) / 269025;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        // t^2.4 = t^2 * (t^2)^(1/5)
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (fifth_q30(mid) <= t2) lo = mid;
          else hi = mid - 1;
        end
        v = (t2 * lo) >> 30;
        lin_lut[i] = (v + (64'd1 << 13)) >> 14;
      end
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mat_q[r][c] = ((c7[r][c] << 16) + 5000000) / 10000000;
  end

  function automatic longint lab_curve(longint unsigned t);
    longint unsigned lo, hi, mid, p;
    if (t * 24389 > (64'd216 << 16)) begin
      lo = 0;
      hi = 64'd1 << 18;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        p   = (mid * mid) >> 16;
        p   = (p * mid) >> 16;
        if (p <= t) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    end
    return longint'((t * 24389 + (64'd432 << 16) + 1566) / 3132);
  endfunction

  // round half up from Q16 to Q8.8
  function automatic longint round_q8(longint v);
    longint w;
    w = v + 128;
    if (w >= 0) return w >>> 8;
    return -((-w + 255) >>> 8);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic s2l_pkg::res_t convert_pixel(s2l_pkg::pix_t p);
    longint unsigned lin [3];
    longint unsigned xyz [3];
    longint          fx, fy, fz, l, a, b;
    s2l_pkg::res_t   r;
    lin[0] = lin_lut[p.red];
    lin[1] = lin_lut[p.green];
    lin[2] = lin_lut[p.blue];
    for (int k = 0; k < 3; k++)
      xyz[k] = (mat_q[k][0] * lin[0] + mat_q[k][1] * lin[1] + mat_q[k][2] * lin[2]
                + 32768) >> 16;
    fx = lab_curve((xyz[0] * white_x + 32768) >> 16);
    fy = lab_curve((xyz[1] * white_y + 32768) >> 16);
    fz = lab_curve((xyz[2] * white_z + 32768) >> 16);
    l = sat(round_q8(116 * fy - (longint'(16) << 16)), 0, 25600);
    a = sat(round_q8(500 * (fx - fy)), -32768, 32767);
    b = sat(round_q8(200 * (fy - fz)), -32768, 32767);
    r.l_star = 15'(l);
    r.a_star = 16'(a);
    r.b_star = 16'(b);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    s2l_pkg::res_t want;
    if (!rst_ni) begin
      white_x <= s2l_pkg::InvWhiteXRst;
      white_y <= s2l_pkg::InvWhiteYRst;
      white_z <= s2l_pkg::InvWhiteZRst;
      lab_expected.delete();
      fail_cnt_o <= 0;
      checked_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          s2l_pkg::CfgInvWhiteX: white_x <= cfg_data_i;
          s2l_pkg::CfgInvWhiteY: white_y <= cfg_data_i;
          s2l_pkg::CfgInvWhiteZ: white_z <= cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) lab_expected.push_back(convert_pixel(pix_i));
      if (res_valid_o) begin
        checked_o <= checked_o + 1;
        if (lab_expected.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = lab_expected.pop_front();
          if (res_o.l_star !== want.l_star)
            $error("l_star: expected %0d actual %0d", want.l_star, res_o.l_star);
          if (res_o.a_star !== want.a_star)
            $error("a_star: expected %0d actual %0d", want.a_star, res_o.a_star);
          if (res_o.b_star !== want.b_star)
            $error("b_star: expected %0d actual %0d", want.b_star, res_o.b_star);
          if (res_o !== want) fail_cnt_o <= fail_cnt_o + 1;
        end
      end
    end
  end

  assign pending_o = lab_expected.size();

endmodule

// ===== sim/tb_srgb_to_cielab.sv =====
// ----------------------------------------------------------------------------
// tb_srgb_to_cielab
// Drives directed and random pixels through srgb_to_cielab under several
// reference-white settings, with random gaps; the checker judges results.
// ----------------------------------------------------------------------------
module tb_srgb_to_cielab;
  timeunit 1ns;
  timeprecision 1ps;

  // unmapped register index, writes to it must be dropped
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int         DrainCycles = 60;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  s2l_pkg::pix_t pix_i = '0;
  logic          res_valid_o;
  s2l_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = s2l_pkg::CfgInvWhiteX;
  logic [16:0]   cfg_data_i = '0;
  int            fail_cnt, pending, checked;
  int            n_pix = 0;
  int            n_cfg = 0;

  srgb_to_cielab dut (.*);

  srgb_lab_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .pix_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // called at a falling edge, returns at a falling edge once the pixel is taken and any random gap has passed
  task automatic send_pixel(s2l_pkg::pix_t p);
    logic b;
    int   gap;
    start = 1'b1;
    pix_i = p;
    do begin
      b = busy;
      @(posedge clk_i);
      @(negedge clk_i);
    end while (b);
    n_pix++;
    case ($urandom_range(0, 19))
      0:       gap = $urandom_range(10, 40);
      1, 2, 3: gap = $urandom_range(1, 4);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      start = 1'b0;
      pix_i = s2l_pkg::pix_t'({$urandom(), $urandom()});
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    logic r;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do begin
      r = cfg_ready_o;
      @(posedge clk_i);
      @(negedge clk_i);
    end while (!r);
    cfg_valid_i = 1'b0;
    n_cfg++;
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic random_pixels(int count);
    for (int k = 0; k < count; k++) begin
      send_pixel(s2l_pkg::pix_t'($urandom()));
      if (k == count / 2) begin
        // let the pipeline run dry once mid-burst
        start = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // black, white, primaries and secondaries, mid grey, and the linear/power gamma boundary
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    send_pixel('{8'd255, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd255});
    send_pixel('{8'd10, 8'd10, 8'd10});
    send_pixel('{8'd11, 8'd11, 8'd11});
    send_pixel('{8'd1, 8'd1, 8'd1});
    send_pixel('{8'd128, 8'd128, 8'd128});
    send_pixel('{8'd10, 8'd11, 8'd254});
    random_pixels(100);
    settle();

    // zero white: every component falls on the linear segment
    write_reg(s2l_pkg::CfgInvWhiteX, 17'd0);
    write_reg(s2l_pkg::CfgInvWhiteY, 17'd0);
    write_reg(s2l_pkg::CfgInvWhiteZ, 17'd0);
    send_pixel('{8'd255, 8'd255, 8'd255});
    random_pixels(40);
    settle();

    // full-scale white: lightness and chroma saturate; one write goes to the unmapped index
    write_reg(s2l_pkg::CfgInvWhiteX, 17'h1FFFF);
    write_reg(s2l_pkg::CfgInvWhiteY, 17'h1FFFF);
    write_reg(s2l_pkg::CfgInvWhiteZ, 17'h1FFFF);
    write_reg(CfgUnused, 17'd0);
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    random_pixels(60);
    settle();

    // lopsided whites push a* to its upper rail and hold b* near zero
    write_reg(s2l_pkg::CfgInvWhiteX, 17'h1FFFF);
    write_reg(s2l_pkg::CfgInvWhiteY, 17'd0);
    write_reg(s2l_pkg::CfgInvWhiteZ, 17'd1);
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    random_pixels(30);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(s2l_pkg::CfgInvWhiteX, 17'($urandom()));
      write_reg(s2l_pkg::CfgInvWhiteY, 17'($urandom()));
      write_reg(s2l_pkg::CfgInvWhiteZ, 17'($urandom()));
      random_pixels(50);
      settle();
    end

    write_reg(s2l_pkg::CfgInvWhiteX, s2l_pkg::InvWhiteXRst);
    write_reg(s2l_pkg::CfgInvWhiteY, s2l_pkg::InvWhiteYRst);
    write_reg(s2l_pkg::CfgInvWhiteZ, s2l_pkg::InvWhiteZRst);
    random_pixels(60);
    settle();

    $display("pixels sent %0d, results checked %0d, register writes %0d",
             n_pix, checked, n_cfg);
    $display("white settings covered: D65, zero, full scale, skewed, random");
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
